// ===== design/rbs_pkg.sv =====
// Shared constants and types for the raster bilinear sampler.
// Used by design/raster_bilinear_sample.sv; depends on nothing else.
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int unsigned MAX_COLUMNS_DEF = 256;
    localparam int unsigned MAX_ROWS_DEF    = 256;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned GRID_DEPTH = 1 << ADDR_W;
    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned SIZE_W     = 9;
    localparam int unsigned CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLUMNS  = 3'd0,
        CFG_GRID_ROWS     = 3'd1,
        CFG_ORIGIN_X      = 3'd2,
        CFG_ORIGIN_Y      = 3'd3,
        CFG_INV_CELL_SIZE = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    localparam logic [SIZE_W-1:0]  GRID_COLUMNS_RST  = 9'd256;
    localparam logic [SIZE_W-1:0]  GRID_ROWS_RST     = 9'd256;
    localparam logic [COORD_W-1:0] INV_CELL_SIZE_RST = 32'h0001_0000;

endpackage

// ===== design/raster_bilinear_sample.sv =====
// Raster bilinear sampler top level: elevation grid storage and query pipeline.
// Depends on rbs_pkg for constants, register indexes and request codes.
`timescale 1ns / 1ps

// One item (grid write or query) is taken every clock cycle; o_busy never rises.
// A query result comes out on o_valid/o_elevation_out one cycle wide, and
// results keep the order of the queries. A query passes the registered
// stages input register, origin subtract, scale multiply, edge clamp,
// address multiply, grid read, x interpolation, y interpolation and the
// output register, in that order. Writes travel the same pipeline and
// land in the grid at the read stage, so every query sees exactly the writes
// accepted before it. The grid is held twice, each copy with two read ports,
// which gives the four neighbour reads in the same cycle. There is no clearing pass:
// reading a grid entry that was never written returns an arbitrary value.
// Configuration writes are always ready and should only be issued while the
// pipeline holds no query.
module raster_bilinear_sample #(
    parameter int unsigned MAX_COLUMNS = rbs_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = rbs_pkg::MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_req_type,
    input  logic [rbs_pkg::ADDR_W-1:0]    i_sample_index,
    input  logic signed [rbs_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic signed [rbs_pkg::COORD_W-1:0]  i_query_x,
    input  logic signed [rbs_pkg::COORD_W-1:0]  i_query_y,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rbs_pkg::COORD_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output logic signed [rbs_pkg::SAMPLE_W-1:0] o_elevation_out
);

    localparam int unsigned MAXD = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int unsigned CNTW = $clog2(MAXD + 1);
    localparam int unsigned IW   = $clog2(MAXD);
    localparam int unsigned AW   = rbs_pkg::ADDR_W;
    localparam int unsigned SW   = rbs_pkg::SAMPLE_W;
    localparam int unsigned CW   = rbs_pkg::COORD_W;

    typedef struct packed {
        logic [IW-1:0] lo;
        logic [IW-1:0] hi;
        logic [15:0]   w;
    } t_axis;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rbs_pkg::SIZE_W-1:0] r_grid_columns;
    logic [rbs_pkg::SIZE_W-1:0] r_grid_rows;
    logic [CW-1:0]              r_origin_x;
    logic [CW-1:0]              r_origin_y;
    logic [CW-1:0]              r_inv_cell_size;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns  <= rbs_pkg::GRID_COLUMNS_RST;
            r_grid_rows     <= rbs_pkg::GRID_ROWS_RST;
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_inv_cell_size <= rbs_pkg::INV_CELL_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rbs_pkg::CFG_GRID_COLUMNS:  r_grid_columns  <= i_cfg_data[rbs_pkg::SIZE_W-1:0];
                rbs_pkg::CFG_GRID_ROWS:     r_grid_rows     <= i_cfg_data[rbs_pkg::SIZE_W-1:0];
                rbs_pkg::CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data;
                rbs_pkg::CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_data;
                rbs_pkg::CFG_INV_CELL_SIZE: r_inv_cell_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [CNTW-1:0] clamp_size(input logic [rbs_pkg::SIZE_W-1:0] v,
                                                   input int unsigned maxv);
        logic [CNTW-1:0] res;
        if (v == '0) begin
            res = CNTW'(1);
        end else if (32'(v) > maxv) begin
            res = CNTW'(maxv);
        end else begin
            res = CNTW'(v);
        end
        return res;
    endfunction

    function automatic t_axis map_axis(input logic neg, input logic [63:0] u,
                                       input logic [CNTW-1:0] count);
        t_axis ax;
        ax.lo = '0;
        ax.hi = '0;
        ax.w  = '0;
        // A point left of the first cell center sits on the first sample.
        if (!(neg && (u != '0))) begin
            ax.w = u[31:16];
            if (({1'b0, u[63:32]} + 33'd1) >= 33'(count)) begin
                ax.lo = IW'(count - CNTW'(1));
                ax.hi = ax.lo;
            end else begin
                ax.lo = IW'(u[63:32]);
                ax.hi = ax.lo + IW'(1);
            end
        end
        return ax;
    endfunction

    logic [CNTW-1:0] cols_c;
    logic [CNTW-1:0] rows_c;
    assign cols_c = clamp_size(r_grid_columns, MAX_COLUMNS);
    assign rows_c = clamp_size(r_grid_rows, MAX_ROWS);

    logic acc;
    assign acc = i_start && !o_busy;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                 r1_vld, r1_typ;
    logic [AW-1:0]        r1_idx;
    logic [SW-1:0]        r1_val;
    logic signed [CW-1:0] r1_qx, r1_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_typ <= i_req_type;
        r1_idx <= i_sample_index;
        r1_val <= i_sample_value;
        r1_qx  <= i_query_x;
        r1_qy  <= i_query_y;
    end

    // ------------------------------------------------------------------
    // Stage 2: subtract origin, take magnitude (always fits 32 bits)
    // ------------------------------------------------------------------
    logic signed [CW:0] dx, dy;
    logic [CW:0]        ndx, ndy;
    assign dx  = {r1_qx[CW-1], r1_qx} - {r_origin_x[CW-1], r_origin_x};
    assign dy  = {r1_qy[CW-1], r1_qy} - {r_origin_y[CW-1], r_origin_y};
    assign ndx = -dx;
    assign ndy = -dy;

    logic            r2_vld, r2_typ, r2_negx, r2_negy;
    logic [AW-1:0]   r2_idx;
    logic [SW-1:0]   r2_val;
    logic [CW-1:0]   r2_magx, r2_magy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_typ  <= r1_typ;
        r2_idx  <= r1_idx;
        r2_val  <= r1_val;
        r2_negx <= dx[CW];
        r2_negy <= dy[CW];
        r2_magx <= dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
        r2_magy <= dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: scale into cell units, Q32.32
    // ------------------------------------------------------------------
    logic [63:0] ux, uy;
    assign ux = 64'(r2_magx) * 64'(r_inv_cell_size);
    assign uy = 64'(r2_magy) * 64'(r_inv_cell_size);

    logic          r3_vld, r3_typ, r3_negx, r3_negy;
    logic [AW-1:0] r3_idx;
    logic [SW-1:0] r3_val;
    logic [63:0]   r3_ux, r3_uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_typ  <= r2_typ;
        r3_idx  <= r2_idx;
        r3_val  <= r2_val;
        r3_negx <= r2_negx;
        r3_negy <= r2_negy;
        r3_ux   <= ux;
        r3_uy   <= uy;
    end

    // ------------------------------------------------------------------
    // Stage 4: split and clamp each axis, flip rows to top-first order
    // ------------------------------------------------------------------
    t_axis ax_x, ax_y;
    assign ax_x = map_axis(r3_negx, r3_ux, cols_c);
    assign ax_y = map_axis(r3_negy, r3_uy, rows_c);

    logic          r4_vld, r4_typ;
    logic [AW-1:0] r4_idx;
    logic [SW-1:0] r4_val;
    logic [IW-1:0] r4_cl, r4_cr, r4_rb, r4_rt;
    logic [15:0]   r4_a, r4_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_typ <= r3_typ;
        r4_idx <= r3_idx;
        r4_val <= r3_val;
        r4_cl  <= ax_x.lo;
        r4_cr  <= ax_x.hi;
        r4_rb  <= IW'(rows_c - CNTW'(1) - CNTW'(ax_y.lo));
        r4_rt  <= IW'(rows_c - CNTW'(1) - CNTW'(ax_y.hi));
        r4_a   <= ax_x.w;
        r4_b   <= ax_y.w;
    end

    // ------------------------------------------------------------------
    // Stage 5: grid addresses, row * columns + column wrapped to 16 bits
    // ------------------------------------------------------------------
    logic [31:0] ad_bl, ad_tl, ad_br, ad_tr;
    assign ad_bl = 32'(r4_rb) * 32'(cols_c) + 32'(r4_cl);
    assign ad_tl = 32'(r4_rt) * 32'(cols_c) + 32'(r4_cl);
    assign ad_br = 32'(r4_rb) * 32'(cols_c) + 32'(r4_cr);
    assign ad_tr = 32'(r4_rt) * 32'(cols_c) + 32'(r4_cr);

    logic          r5_vld, r5_typ;
    logic [SW-1:0] r5_val;
    logic [AW-1:0] r5_ad_bl, r5_ad_tl, r5_ad_br, r5_ad_tr;
    logic [15:0]   r5_a, r5_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    // A write item carries its target in the first address slot.
    always_ff @(posedge i_clk) begin
        r5_typ   <= r4_typ;
        r5_val   <= r4_val;
        r5_ad_bl <= (r4_typ == rbs_pkg::REQ_QUERY) ? ad_bl[AW-1:0] : r4_idx;
        r5_ad_tl <= ad_tl[AW-1:0];
        r5_ad_br <= ad_br[AW-1:0];
        r5_ad_tr <= ad_tr[AW-1:0];
        r5_a     <= r4_a;
        r5_b     <= r4_b;
    end

    // ------------------------------------------------------------------
    // Stage 6: grid access. Two identical copies, two read ports each.
    // ------------------------------------------------------------------
    logic [SW-1:0] mem_left  [rbs_pkg::GRID_DEPTH];
    logic [SW-1:0] mem_right [rbs_pkg::GRID_DEPTH];
    logic [SW-1:0] r6_s_bl, r6_s_tl, r6_s_br, r6_s_tr;
    logic          r6_vld;
    logic [15:0]   r6_a, r6_b;
    logic          wr_en;

    assign wr_en = r5_vld && (r5_typ == rbs_pkg::REQ_WRITE);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_left[r5_ad_bl] <= r5_val;
        end
        r6_s_bl <= mem_left[r5_ad_bl];
        r6_s_tl <= mem_left[r5_ad_tl];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_right[r5_ad_bl] <= r5_val;
        end
        r6_s_br <= mem_right[r5_ad_br];
        r6_s_tr <= mem_right[r5_ad_tr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld && (r5_typ == rbs_pkg::REQ_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        r6_a <= r5_a;
        r6_b <= r5_b;
    end

    // ------------------------------------------------------------------
    // Stage 7: interpolate along x for the bottom and top rows
    // ------------------------------------------------------------------
    logic signed [17:0] wa0, wa1;
    logic signed [41:0] p_bl, p_br, p_tl, p_tr;
    assign wa0  = $signed(18'h10000 - {2'b00, r6_a});
    assign wa1  = $signed({2'b00, r6_a});
    assign p_bl = wa0 * $signed(r6_s_bl);
    assign p_br = wa1 * $signed(r6_s_br);
    assign p_tl = wa0 * $signed(r6_s_tl);
    assign p_tr = wa1 * $signed(r6_s_tr);

    logic               r7_vld;
    logic signed [42:0] r7_row_b, r7_row_t;
    logic [15:0]        r7_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_row_b <= {p_bl[41], p_bl} + {p_br[41], p_br};
        r7_row_t <= {p_tl[41], p_tl} + {p_tr[41], p_tr};
        r7_b     <= r6_b;
    end

    // ------------------------------------------------------------------
    // Stage 8: interpolate along y, exact sum scaled by 2^32
    // ------------------------------------------------------------------
    logic signed [17:0] wb0, wb1;
    logic signed [60:0] p_b, p_t;
    assign wb0 = $signed(18'h10000 - {2'b00, r7_b});
    assign wb1 = $signed({2'b00, r7_b});
    assign p_b = r7_row_b * wb0;
    assign p_t = r7_row_t * wb1;

    logic               r8_vld;
    logic signed [61:0] r8_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_sum <= {p_b[60], p_b} + {p_t[60], p_t};
    end

    // ------------------------------------------------------------------
    // Output: divide by 2^32 truncating toward zero
    // ------------------------------------------------------------------
    logic [29:0] hi_part;
    logic        round_up;
    logic [29:0] n_res;
    assign hi_part  = r8_sum[61:32];
    assign round_up = r8_sum[61] && (r8_sum[31:0] != '0);
    assign n_res    = hi_part + 30'(round_up);

    logic          r_valid;
    logic [SW-1:0] r_elev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elev <= n_res[SW-1:0];
    end

    assign o_valid         = r_valid;
    assign o_elevation_out = r_elev;

endmodule
